/* rtl/sector_cache_tag_controller_assert.svh */
// Assertion macros for the sector cache tag controller.
`ifndef SECTOR_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SECTOR_CACHE_TAG_CONTROLLER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/sct_pkg.sv */
// Package with shared types and codes of the sector cache tag controller.
`default_nettype none
package sct_pkg;
    localparam int unsigned SectorW = 32;
    localparam int unsigned SlotW   = 6;
    localparam int unsigned OutLimit = 64;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_FLUSH   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_ALL_PINNED = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_FLUSH_WB   = 3'd4,
        ST_FLUSH_DONE = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic [SectorW-1:0] sector;
        logic               hold_pin;
        logic [SlotW-1:0]   slot;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [SlotW-1:0]   slot_index;
        logic               writeback_valid;
        logic [SectorW-1:0] writeback_sector;
        logic [SectorW-1:0] fill_sector;
        logic               last;
    } t_rsp;
endpackage
`default_nettype wire

/* rtl/sct_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface sct_req_if;
    import sct_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sct_rsp_if;
    import sct_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/sector_cache_tag_controller.sv */
// Top level of the sector cache tag controller.
//
//  channel  | dir | payload                                          | handshake
//  i_req    | in  | command, sector, hold_pin, slot                  | valid/ready
//  o_rsp    | out | status, slot_index, writeback_valid/_sector,     | valid/ready
//           |     | fill_sector, last                                |
//
// A release answers from S_FINISH. A read or write scans the tags from slot 0 in
// S_LOOK up to a hit; a miss fills the lowest free slot, or else S_EVICT skips pinned
// slots round-robin up to a victim or answers all pinned. A flush walks the slots and
// writes back each dirty one, up to OutLimit. One request is in flight at a time;
// the next is taken only in S_IDLE after the final response is accepted. Reset is
// synchronous and clears valid, dirty and the victim pointer; the tag and pin
// memories need no clearing pass since a slot that is not valid reads as unpinned.
// A stalled response holds the flush walk.
`default_nettype none
module sector_cache_tag_controller #(
    parameter int unsigned ENTRIES  = 64,
    parameter int unsigned PIN_BITS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sct_req_if.sink   i_req,
    sct_rsp_if.source o_rsp
);
    import sct_pkg::*;

    localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(ENTRIES + 1);
    localparam int unsigned FlW  = $clog2(OutLimit + 1);
    localparam logic [PIN_BITS-1:0] PinMax = {PIN_BITS{1'b1}};
    localparam logic [CntW-1:0] LastIdx = CntW'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOK   = 6'b000010,
        S_EVICT  = 6'b000100,
        S_FINISH = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Valid and dirty state live in flip-flops so reset clears them.
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [ENTRIES-1:0] r_dirty, n_dirty;
    logic [IdxW-1:0] r_vptr, n_vptr;

    t_req r_req, n_req;
    logic [CntW-1:0] r_cnt, n_cnt;     // slot whose tag is being read
    logic [CntW-1:0] r_steps, n_steps; // eviction steps taken
    logic r_rd_v, n_rd_v;              // a read was issued last cycle
    logic [IdxW-1:0] r_rd_idx, n_rd_idx;
    logic [IdxW-1:0] r_found, n_found;
    logic r_hit, n_hit;
    logic [FlW-1:0] r_nflush, n_nflush;
    logic r_any, n_any;
    t_rsp r_rsp, n_rsp;
    logic r_ovalid, n_ovalid;

    logic              we;
    logic [IdxW-1:0]   waddr, raddr;
    logic [SectorW-1:0] wdata, rdata;

    sct_ram #(.WIDTH(SectorW), .DEPTH(ENTRIES)) u_tag (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Pin counts sit in a second memory; a slot that is not valid counts as unpinned.
    logic                pin_we;
    logic [IdxW-1:0]     pin_waddr, pin_raddr;
    logic [PIN_BITS-1:0] pin_wdata, pin_rdata;

    sct_ram #(.WIDTH(PIN_BITS), .DEPTH(ENTRIES)) u_pin (
        .i_clk  (i_clk),
        .i_we   (pin_we),
        .i_waddr(pin_waddr),
        .i_wdata(pin_wdata),
        .i_raddr(pin_raddr),
        .o_rdata(pin_rdata)
    );

    logic [IdxW-1:0]     pin_tgt;
    logic [PIN_BITS-1:0] pin_cur;
    assign pin_tgt = (r_req.command == CMD_RELEASE) ? IdxW'(r_req.slot) : r_found;
    assign pin_cur = r_valid[pin_tgt] ? pin_rdata : '0;

    // Lowest free slot: a priority scan over valid bits.
    logic            free_any;
    logic [IdxW-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    // A dirty slot above the one being written back means this is not the last.
    logic more_dirty;
    always_comb begin
        more_dirty = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (IdxW'(i) > r_rd_idx && r_valid[i] && r_dirty[i]) begin
                more_dirty = 1'b1;
            end
        end
    end

    logic [IdxW-1:0] ev_idx;
    always_comb begin
        if (r_cnt == LastIdx) begin
            ev_idx = '0;
        end else begin
            ev_idx = IdxW'(r_cnt + 1'b1);
        end
    end

    logic stall;
    assign stall = r_ovalid && !o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_vptr  = r_vptr;
        n_req   = r_req;
        n_cnt   = r_cnt;
        n_steps = r_steps;
        n_rd_v  = 1'b0;
        n_rd_idx = r_rd_idx;
        n_found = r_found;
        n_hit   = r_hit;
        n_nflush = r_nflush;
        n_any   = r_any;
        n_rsp   = r_rsp;
        n_ovalid = r_ovalid && !o_rsp.ready;
        we    = 1'b0;
        waddr = r_found;
        wdata = r_req.sector;
        raddr = r_cnt[IdxW-1:0];
        pin_we    = 1'b0;
        pin_waddr = pin_tgt;
        pin_wdata = pin_cur;
        pin_raddr = r_cnt[IdxW-1:0];

        unique case (r_state)
            S_IDLE: begin
                // A release needs the pin count of its slot in the next cycle.
                pin_raddr = IdxW'(i_req.data.slot);
                if (i_req.valid && i_req.ready) begin
                    n_req = i_req.data;
                    n_cnt = '0;
                    n_hit = 1'b0;
                    n_nflush = '0;
                    n_any = 1'b0;
                    unique case (i_req.data.command)
                        CMD_RELEASE: n_state = S_FINISH;
                        CMD_FLUSH:   n_state = S_FLUSH;
                        default:     n_state = S_LOOK;
                    endcase
                end
            end
            S_LOOK: begin
                // One tag read per cycle; compare the one read last cycle.
                if (r_rd_v && r_valid[r_rd_idx] && rdata == r_req.sector) begin
                    n_hit = 1'b1;
                    n_found = r_rd_idx;
                    pin_raddr = r_rd_idx;
                    n_state = S_FINISH;
                end else if (r_cnt == CntW'(ENTRIES)) begin
                    if (free_any) begin
                        n_found = free_idx;
                        pin_raddr = free_idx;
                        n_state = S_FINISH;
                    end else begin
                        n_cnt = CntW'(r_vptr);
                        n_steps = '0;
                        n_state = S_EVICT;
                    end
                end else begin
                    n_rd_v = 1'b1;
                    n_rd_idx = r_cnt[IdxW-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EVICT: begin
                // Round-robin search for an unpinned victim. Tag and pin count
                // of a slot are read together and checked in the next cycle;
                // the victim's tag is read again so it is on hand in S_FINISH.
                if (r_rd_v && pin_rdata == '0) begin
                    n_found = r_rd_idx;
                    raddr = r_rd_idx;
                    pin_raddr = r_rd_idx;
                    n_state = S_FINISH;
                end else if (r_steps == CntW'(ENTRIES)) begin
                    n_rsp = '{status: ST_ALL_PINNED, slot_index: '0,
                              writeback_valid: 1'b0, writeback_sector: '0,
                              fill_sector: '0, last: 1'b1};
                    n_ovalid = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_rd_v = 1'b1;
                    n_rd_idx = r_cnt[IdxW-1:0];
                    n_cnt = CntW'(ev_idx);
                    n_steps = r_steps + 1'b1;
                end
            end
            S_FINISH: begin
                n_ovalid = 1'b1;
                n_state = S_OUT;
                if (r_req.command == CMD_RELEASE) begin
                    n_rsp = '{status: ST_RELEASED, slot_index: r_req.slot,
                              writeback_valid: 1'b0, writeback_sector: '0,
                              fill_sector: '0, last: 1'b1};
                end else if (r_hit) begin
                    n_rsp = '{status: ST_HIT, slot_index: SlotW'(r_found),
                              writeback_valid: 1'b0, writeback_sector: '0,
                              fill_sector: '0, last: 1'b1};
                    if (r_req.command == CMD_WRITE) begin
                        n_dirty[r_found] = 1'b1;
                    end
                end else begin
                    // Miss: a victim (all valid) carries rdata as its old tag.
                    n_rsp = '{status: ST_MISS, slot_index: SlotW'(r_found),
                              writeback_valid: r_valid[r_found] && r_dirty[r_found],
                              writeback_sector: (r_valid[r_found] && r_dirty[r_found])
                                                ? rdata : '0,
                              fill_sector: r_req.sector, last: 1'b1};
                    if (r_valid[r_found]) begin
                        n_vptr = (r_found == IdxW'(ENTRIES - 1)) ? '0 : r_found + 1'b1;
                    end
                    n_valid[r_found] = 1'b1;
                    n_dirty[r_found] = (r_req.command == CMD_WRITE);
                    we = 1'b1;
                end
                // Pin update: a release drops one pin, a held read adds one, both
                // saturate. Any in-range access writes its slot so a new fill starts clean.
                if (r_req.command == CMD_RELEASE) begin
                    if (32'(r_req.slot) < ENTRIES) begin
                        pin_we = 1'b1;
                        if (pin_cur != '0) begin
                            pin_wdata = pin_cur - 1'b1;
                        end
                    end
                end else begin
                    pin_we = 1'b1;
                    if (r_req.command == CMD_READ && r_req.hold_pin && pin_cur != PinMax) begin
                        pin_wdata = pin_cur + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                // Walk slots; rdata holds the tag of r_rd_idx.
                if (!stall) begin
                    if (r_rd_v) begin
                        n_dirty[r_rd_idx] = 1'b0;
                        n_rsp = '{status: ST_FLUSH_WB, slot_index: SlotW'(r_rd_idx),
                                  writeback_valid: 1'b1, writeback_sector: rdata,
                                  fill_sector: '0,
                                  last: !more_dirty || (r_nflush == FlW'(OutLimit - 1))};
                        n_ovalid = 1'b1;
                        n_any = 1'b1;
                        n_nflush = r_nflush + 1'b1;
                    end
                    if (r_cnt < CntW'(ENTRIES) && n_nflush < FlW'(OutLimit)
                            && r_valid[r_cnt[IdxW-1:0]] && r_dirty[r_cnt[IdxW-1:0]]) begin
                        n_rd_v = 1'b1;
                        n_rd_idx = r_cnt[IdxW-1:0];
                    end
                    if (r_cnt < CntW'(ENTRIES)) begin
                        n_cnt = r_cnt + 1'b1;
                    end else if (!r_rd_v) begin
                        n_state = S_OUT;
                        if (!r_any) begin
                            n_rsp = '{status: ST_FLUSH_DONE, slot_index: '0,
                                      writeback_valid: 1'b0, writeback_sector: '0,
                                      fill_sector: '0, last: 1'b1};
                            n_ovalid = 1'b1;
                        end
                    end
                end else begin
                    n_rd_v = r_rd_v;
                    raddr = r_rd_idx;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A stall freezes the flush walk and the pending tag read is reissued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_vptr   <= '0;
            r_ovalid <= 1'b0;
            r_rd_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_dirty  <= n_dirty;
            r_vptr   <= n_vptr;
            r_ovalid <= n_ovalid;
            r_rd_v   <= n_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_cnt    <= n_cnt;
        r_steps  <= n_steps;
        r_rd_idx <= n_rd_idx;
        r_found  <= n_found;
        r_hit    <= n_hit;
        r_nflush <= n_nflush;
        r_any    <= n_any;
        r_rsp    <= n_rsp;
    end
endmodule
`default_nettype wire

/* rtl/sct_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module sct_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/sct_checker.sv */
// Port-level checker of the sector cache tag controller and its bind.
`default_nettype none
`include "sector_cache_tag_controller_assert.svh"
module sct_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_ready,
    input wire logic o_valid,
    input wire logic o_ready,
    input wire logic [2:0] o_status,
    input wire logic o_wb_valid,
    input wire logic o_last
);
    import sct_pkg::*;
    `SCT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !o_ready, o_valid,
        "response dropped while stalled")
    `SCT_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_valid, !(i_valid && i_ready),
        "request accepted with response pending")
    `SCT_ASSERT_IMPL(a_single_last, i_clk, i_rst_n,
        o_valid && (o_status != ST_FLUSH_WB), o_last,
        "single-result response without last")
    `SCT_ASSERT_IMPL(a_wb_status, i_clk, i_rst_n, o_valid && o_wb_valid,
        (o_status == ST_MISS) || (o_status == ST_FLUSH_WB),
        "writeback on wrong status")
endmodule

bind sector_cache_tag_controller sct_checker u_sct_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_req.valid),
    .i_ready   (i_req.ready),
    .o_valid   (o_rsp.valid),
    .o_ready   (o_rsp.ready),
    .o_status  (o_rsp.data.status),
    .o_wb_valid(o_rsp.data.writeback_valid),
    .o_last    (o_rsp.data.last)
);
`default_nettype wire
